>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the shuffler RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge of clock, ignored while reset is high
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every rising edge of clock, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/xfys_pkg.sv
// ----------------------------------------------------------------------------
// xfys_pkg
// Types, constants and the generator step shared by the shuffler modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xfys_pkg;

   localparam int CARD_W   = 16;
   localparam int SEED_W   = 32;
   localparam int SHIFT_A  = 13;
   localparam int SHIFT_B  = 17;
   localparam int SHIFT_C  = 5;
   localparam int DIV_STEPS = SEED_W;
   localparam int STEP_W   = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   // memory access chosen by the controller in each state
   typedef enum logic [2:0] {
      MEM_IDLE,
      MEM_RD_I,
      MEM_RD_J,
      MEM_WR_I,
      MEM_WR_J,
      MEM_RD_EMIT
   } mem_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       prep;
      logic       gen_step;
      logic       div_step;
      logic       emit;
      mem_op_type mem_op;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic cnt_one;
      logic pos_one;
      logic div_last;
      logic emit_last;
   } dp_status_type;

   // one xorshift32 step
   function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] v);
      logic [SEED_W-1:0] a;
      logic [SEED_W-1:0] b;
      a = v ^ (v << SHIFT_A);
      b = a ^ (a >> SHIFT_B);
      return b ^ (b << SHIFT_C);
   endfunction

endpackage

>>> sv/xfys_ram.sv
// ----------------------------------------------------------------------------
// xfys_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xfys_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/xfys_ctrl.sv
// ----------------------------------------------------------------------------
// xfys_ctrl
// Sequencer for loading, the swap pass and emitting the shuffled list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xfys_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_is_last,
   input  xfys_pkg::dp_status_type status,
   output logic                   busy,
   output xfys_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_GEN,
      ST_DIV,
      ST_RD_I,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_is_last) state_in = ST_PREP;
         end
         ST_PREP: state_in = status.cnt_one ? ST_EMIT : ST_GEN;
         ST_GEN:  state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_last) state_in = ST_RD_I;
         end
         ST_RD_I: state_in = ST_RD_J;
         ST_RD_J: state_in = ST_WR_I;
         ST_WR_I: state_in = ST_WR_J;
         ST_WR_J: state_in = status.pos_one ? ST_EMIT : ST_GEN;
         ST_EMIT: begin
            if (status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.mem_op   = xfys_pkg::MEM_IDLE;
      unique case (state_ff)
         ST_IDLE: cmd.load = start;
         ST_PREP: cmd.prep = 1'b1;
         ST_GEN:  cmd.gen_step = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_RD_I: cmd.mem_op = xfys_pkg::MEM_RD_I;
         ST_RD_J: cmd.mem_op = xfys_pkg::MEM_RD_J;
         ST_WR_I: cmd.mem_op = xfys_pkg::MEM_WR_I;
         ST_WR_J: cmd.mem_op = xfys_pkg::MEM_WR_J;
         ST_EMIT: begin
            cmd.emit   = 1'b1;
            cmd.mem_op = xfys_pkg::MEM_RD_EMIT;
         end
         default: cmd.mem_op = xfys_pkg::MEM_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> sv/xfys_dp.sv
// ----------------------------------------------------------------------------
// xfys_dp
// Datapath: entry store, generator, serial remainder unit and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xfys_dp #(
   parameter int LIST_CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  xfys_pkg::ctrl_cmd_type            cmd,
   output xfys_pkg::dp_status_type           status,
   input  logic [xfys_pkg::CARD_W-1:0]       req_card_index,
   input  logic                              csr_wr_en,
   input  logic [xfys_pkg::SEED_W-1:0]       csr_wr_data,
   output logic                              rsp_strobe,
   output logic [xfys_pkg::CARD_W-1:0]       rsp_shuffled_index,
   output logic                              rsp_end_of_list
);

   localparam int ADDR_W = $clog2(LIST_CAPACITY);
   localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(LIST_CAPACITY);

   logic [xfys_pkg::SEED_W-1:0] seed_ff;
   logic [xfys_pkg::SEED_W-1:0] gen_ff, gen_in;
   logic [xfys_pkg::SEED_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]            rem_ff, rem_in;
   logic [xfys_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [ADDR_W-1:0]           pos_ff, pos_in;
   logic [xfys_pkg::CARD_W-1:0] tmp_ff;
   logic                        strobe_ff, strobe_in;
   logic                        end_ff, end_in;

   logic [xfys_pkg::SEED_W-1:0] gen_next;
   logic [CNT_W:0]              rem_shift;
   logic [CNT_W:0]              divisor;
   logic                        full;

   logic                        ram_wr_en;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [xfys_pkg::CARD_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [ADDR_W-1:0]           ram_rd_addr;
   logic [xfys_pkg::CARD_W-1:0] ram_rd_data;

   assign full     = (count_ff >= CAP);
   assign gen_next = xfys_pkg::xorshift32(gen_ff);

   // one restoring step of the remainder by position plus one
   assign divisor   = (CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(1);
   assign rem_shift = {rem_ff, quo_ff[xfys_pkg::SEED_W-1]};

   // status towards the controller
   assign status.cnt_one   = (count_ff == CNT_W'(1));
   assign status.pos_one   = (pos_ff == ADDR_W'(1));
   assign status.div_last  = (step_ff == xfys_pkg::STEP_LAST);
   assign status.emit_last = ((CNT_W)'(pos_ff) == count_ff - CNT_W'(1));

   // next values of the working registers
   always_comb begin
      gen_in    = gen_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      strobe_in = 1'b0;
      end_in    = 1'b0;

      // entry transfer: seed on first entry, count up until full
      if (cmd.load) begin
         if (count_ff == '0) gen_in = seed_ff | xfys_pkg::SEED_W'(1);
         if (!full) count_in = count_ff + CNT_W'(1);
      end

      if (cmd.prep) pos_in = ADDR_W'(count_ff - CNT_W'(1));

      // new generator value, remainder restarts
      if (cmd.gen_step) begin
         gen_in  = gen_next;
         quo_in  = gen_next;
         rem_in  = '0;
         step_in = '0;
      end

      if (cmd.div_step) begin
         quo_in  = quo_ff << 1;
         step_in = step_ff + xfys_pkg::STEP_W'(1);
         if (rem_shift >= divisor) begin
            rem_in = CNT_W'(rem_shift - divisor);
         end else begin
            rem_in = CNT_W'(rem_shift);
         end
      end

      if (cmd.mem_op == xfys_pkg::MEM_WR_J) pos_in = pos_ff - ADDR_W'(1);

      // emit walks the store from the bottom
      if (cmd.emit) begin
         strobe_in = 1'b1;
         end_in    = status.emit_last;
         if (status.emit_last) begin
            pos_in   = '0;
            count_in = '0;
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= xfys_pkg::SEED_W'(1);
         gen_ff    <= xfys_pkg::SEED_W'(1);
         count_ff  <= '0;
         pos_ff    <= '0;
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) seed_ff <= csr_wr_data;
         gen_ff    <= gen_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      end_ff <= end_in;
      if (cmd.mem_op == xfys_pkg::MEM_RD_J) tmp_ff <= ram_rd_data;
   end

   // store port selection
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_wr_data = req_card_index;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff;
      unique case (cmd.mem_op)
         xfys_pkg::MEM_IDLE: ram_wr_en = cmd.load && !full;
         xfys_pkg::MEM_RD_I: ram_rd_en = 1'b1;
         xfys_pkg::MEM_RD_J: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = rem_ff[ADDR_W-1:0];
         end
         xfys_pkg::MEM_WR_I: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = ram_rd_data;
         end
         xfys_pkg::MEM_WR_J: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rem_ff[ADDR_W-1:0];
            ram_wr_data = tmp_ff;
         end
         xfys_pkg::MEM_RD_EMIT: ram_rd_en = 1'b1;
         default: ram_wr_en = 1'b0;
      endcase
   end

   xfys_ram #(
      .WIDTH (xfys_pkg::CARD_W),
      .DEPTH (LIST_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe         = strobe_ff;
   assign rsp_shuffled_index = ram_rd_data;
   assign rsp_end_of_list    = end_ff;

endmodule

>>> sv/xorshift_fisher_yates_shuffle.sv
// ----------------------------------------------------------------------------
// xorshift_fisher_yates_shuffle
// Stores a list of card indices, shuffles it in place with a Fisher-Yates
// pass driven by xorshift32, then streams the permuted list out
// ----------------------------------------------------------------------------
//
//  channel   ports                       transfer when
//  -------   -------------------------   ------------------------------
//  request   req_card_index, req_is_last  start high and busy low
//  response  rsp_shuffled_index, rsp_end_of_list  rsp_strobe high
//  csr       csr_wr_data                  csr_wr_en high
//
//  an entry without the last mark leaves busy low
//  a list of n entries then runs n-1 swaps, each a generator step, the
//  bit-serial remainder over the 32 bits of the generator value and four
//  store accesses, then emits all n entries through the single read port
//  of the store; reset is synchronous and active high; the store is not cleared
//  the response side cannot stall; one result per strobe
//
`timescale 1ns / 1ps

`include "assert_macros.svh"

module xorshift_fisher_yates_shuffle #(
   parameter int LIST_CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [xfys_pkg::CARD_W-1:0] req_card_index,
   input  logic                        req_is_last,
   output logic                        rsp_strobe,
   output logic [xfys_pkg::CARD_W-1:0] rsp_shuffled_index,
   output logic                        rsp_end_of_list,
   input  logic                        csr_wr_en,
   input  logic [xfys_pkg::SEED_W-1:0] csr_wr_data
);

   xfys_pkg::ctrl_cmd_type  cmd;
   xfys_pkg::dp_status_type status;

   // sequencer
   xfys_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_is_last (req_is_last),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   // datapath
   xfys_dp #(
      .LIST_CAPACITY (LIST_CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_card_index     (req_card_index),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_shuffled_index (rsp_shuffled_index),
      .rsp_end_of_list    (rsp_end_of_list)
   );

   // results only come out of a shuffle that was running
   `ASSERT_SYNC(a_strobe_after_busy, rsp_strobe |-> $past(busy), "result without a running list")
   // end mark only rides on a result
   `ASSERT_ALWAYS(a_end_with_strobe, rsp_end_of_list && !reset |-> rsp_strobe, "end mark without result")
   // nothing follows the final result directly
   `ASSERT_SYNC(a_quiet_after_end, rsp_strobe && rsp_end_of_list |=> !rsp_strobe, "result after end of list")
   // the remainder unit only steps while shuffling
   `ASSERT_SYNC(a_no_load_while_busy, cmd.div_step |-> busy && !cmd.load, "remainder step outside shuffle")

endmodule
